// ===== hw/rtl/sha1md_pkg.sv =====
`timescale 1ns / 1ps

package sha1md_pkg;

    localparam int WIN_DEPTH = 16;
    localparam int CHAIN_N = 5;

    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN = 6'd56;
    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST = 3'd4;
    localparam logic [2:0] LEN_BYTES_LAST = 3'd7;

    typedef logic [31:0] word_t;

    localparam word_t IV [CHAIN_N] = '{
        32'h67452301,
        32'hEFCDAB89,
        32'h98BADCFE,
        32'h10325476,
        32'hC3D2E1F0
    };

    // Round groups of twenty, each with its own constant; the two parity groups share one mixing function.
    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY_LO,
        PH_MAJORITY,
        PH_PARITY_HI
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_COMPRESS,
        ST_FINAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } digest_item_t;

    typedef struct packed {
        logic       wr;
        logic [5:0] pos;
        logic [7:0] wr_byte;
        logic       shift;
    } sched_ctrl_t;

    typedef struct packed {
        logic   init;
        logic   start;
        logic   step;
        logic   finish;
        phase_t phase;
    } round_ctrl_t;

    function automatic word_t round_k(phase_t ph);
        word_t k;
        unique case (ph)
            PH_CHOOSE:    k = 32'h5A827999;
            PH_PARITY_LO: k = 32'h6ED9EBA1;
            PH_MAJORITY:  k = 32'h8F1BBCDC;
            PH_PARITY_HI: k = 32'hCA62C1D6;
            default:      k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

    function automatic word_t round_f(phase_t ph, word_t b, word_t c, word_t d);
        word_t f;
        unique case (ph)
            PH_CHOOSE:   f = (b & c) | (~b & d);
            PH_MAJORITY: f = (b & c) | (b & d) | (c & d);
            default:     f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

// ===== hw/rtl/sha1md_sched.sv =====
`timescale 1ns / 1ps

module sha1md_sched (
    input  logic                    clk,
    input  sha1md_pkg::sched_ctrl_t ctrl,
    output sha1md_pkg::word_t       w_cur
);
    import sha1md_pkg::*;

    word_t win_reg [WIN_DEPTH];
    word_t expand;
    word_t mix;

    // The window holds W[i] .. W[i+15]; the new word is W[i+16].
    assign mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign expand = {mix[30:0], mix[31]};
    assign w_cur = win_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[WIN_DEPTH - 1] <= expand;
        end
        else if (ctrl.wr)
        begin
            // Byte zero of a word is its most significant byte.
            win_reg[ctrl.pos[5:2]][{~ctrl.pos[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
        end
    end

endmodule

// ===== hw/rtl/sha1md_round.sv =====
`timescale 1ns / 1ps

module sha1md_round (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  sha1md_pkg::round_ctrl_t                       ctrl,
    input  sha1md_pkg::word_t                             w_cur,
    output sha1md_pkg::word_t [sha1md_pkg::CHAIN_N-1:0]   chain
);
    import sha1md_pkg::*;

    word_t [CHAIN_N-1:0] chain_reg;
    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t t_next;

    assign chain = chain_reg;

    assign t_next = {a_reg[26:0], a_reg[31:27]} + round_f(ctrl.phase, b_reg, c_reg, d_reg)
                    + e_reg + round_k(ctrl.phase) + w_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAIN_N; i++)
            begin
                chain_reg[i] <= IV[i];
            end
        end
        else if (ctrl.init)
        begin
            for (int i = 0; i < CHAIN_N; i++)
            begin
                chain_reg[i] <= IV[i];
            end
        end
        else if (ctrl.finish)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (ctrl.step)
        begin
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

endmodule

// ===== hw/rtl/sha1_message_digest.sv =====
`timescale 1ns / 1ps
// A byte that does not complete a 64-byte block leaves the input ready for the next byte.
// A byte that completes a block is followed by a busy period (80 rounds and the chaining add)
// on the single round unit, during which no new byte is taken.
// End of message pads one byte per cycle outside compressions, runs one or two compressions, then
// offers five digest words, one per cycle while the output is ready.
// Reset (rst_n, asynchronous, active low) loads the initial hash and zeroes the byte count.

module sha1_message_digest (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  sha1md_pkg::msg_item_t    item,
    output logic                     digest_valid,
    input  logic                     digest_ready,
    output sha1md_pkg::digest_item_t digest
);
    import sha1md_pkg::*;

    localparam logic [6:0] ROUND_PH1 = 7'd20;
    localparam logic [6:0] ROUND_PH2 = 7'd40;
    localparam logic [6:0] ROUND_PH3 = 7'd60;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    state_t      after_push;
    logic [60:0] byte_cnt_reg, byte_cnt_next, byte_cnt_inc;
    logic [63:0] len_reg, len_next;
    logic [6:0]  rnd_cnt_reg, rnd_cnt_next;
    logic [2:0]  sub_reg, sub_next;
    logic [5:0]  pos;
    logic        push_en;
    logic [7:0]  push_val;

    sched_ctrl_t         sch;
    round_ctrl_t         rc;
    word_t               w_cur;
    word_t [CHAIN_N-1:0] chain;

    assign pos = byte_cnt_reg[5:0];
    assign byte_cnt_inc = byte_cnt_reg + 61'd1;

    sha1md_sched u_sched (
        .clk   (clk),
        .ctrl  (sch),
        .w_cur (w_cur)
    );

    sha1md_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rc),
        .w_cur (w_cur),
        .chain (chain)
    );

    assign digest.digest_word = chain[sub_reg];
    assign digest.word_index = sub_reg;
    assign digest.last_word = (sub_reg == WORD_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg <= ST_IDLE;
            byte_cnt_reg <= '0;
            rnd_cnt_reg <= '0;
            sub_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            byte_cnt_reg <= byte_cnt_next;
            rnd_cnt_reg <= rnd_cnt_next;
            sub_reg <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        byte_cnt_next = byte_cnt_reg;
        len_next = len_reg;
        rnd_cnt_next = rnd_cnt_reg;
        sub_next = sub_reg;
        after_push = state_reg;
        push_en = 1'b0;
        push_val = PAD_ZERO_BYTE;
        item_ready = 1'b0;
        digest_valid = 1'b0;
        sch = '0;
        rc = '0;

        priority if (rnd_cnt_reg < ROUND_PH1)
            rc.phase = PH_CHOOSE;
        else if (rnd_cnt_reg < ROUND_PH2)
            rc.phase = PH_PARITY_LO;
        else if (rnd_cnt_reg < ROUND_PH3)
            rc.phase = PH_MAJORITY;
        else
            rc.phase = PH_PARITY_HI;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    // The length is captured after the byte of the same transaction.
                    len_next = item.byte_present ? {byte_cnt_inc, 3'b000}
                                                 : {byte_cnt_reg, 3'b000};
                    push_en = item.byte_present;
                    push_val = item.data_byte;
                    after_push = item.end_of_message ? ST_PAD_MARK : ST_IDLE;
                    if (!item.byte_present && item.end_of_message)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                push_en = 1'b1;
                push_val = PAD_MARK_BYTE;
                after_push = ST_PAD_ZERO;
            end
            ST_PAD_ZERO:
            begin
                if (pos == POS_LEN)
                begin
                    state_next = ST_PAD_LEN;
                    sub_next = '0;
                end
                else
                begin
                    push_en = 1'b1;
                    push_val = PAD_ZERO_BYTE;
                    after_push = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN:
            begin
                push_en = 1'b1;
                push_val = len_reg[63:56];
                len_next = {len_reg[55:0], 8'h00};
                sub_next = sub_reg + 3'd1;
                after_push = (sub_reg == LEN_BYTES_LAST) ? ST_EMIT : ST_PAD_LEN;
            end
            ST_COMPRESS:
            begin
                rc.step = 1'b1;
                sch.shift = 1'b1;
                rnd_cnt_next = rnd_cnt_reg + 7'd1;
                if (rnd_cnt_reg == ROUND_LAST)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                rc.finish = 1'b1;
                state_next = ret_reg;
            end
            ST_EMIT:
            begin
                digest_valid = 1'b1;
                if (digest_ready)
                begin
                    sub_next = sub_reg + 3'd1;
                    if (sub_reg == WORD_LAST)
                    begin
                        rc.init = 1'b1;
                        byte_cnt_next = '0;
                        sub_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A byte that fills the block starts compression; the round unit loads
        // the chaining words in the same cycle.
        sch.pos = pos;
        if (push_en)
        begin
            sch.wr = 1'b1;
            sch.wr_byte = push_val;
            byte_cnt_next = byte_cnt_inc;
            if (pos == POS_LAST)
            begin
                rc.start = 1'b1;
                rnd_cnt_next = '0;
                ret_next = after_push;
                state_next = ST_COMPRESS;
            end
            else
            begin
                state_next = after_push;
            end
        end
    end

    ap_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && digest_valid))
        else $error("input and output sides active together");

    ap_len_position: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PAD_LEN |-> pos == {3'b111, sub_reg})
        else $error("length bytes not at the end of the block");

    ap_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COMPRESS |-> rnd_cnt_reg <= ROUND_LAST)
        else $error("round counter out of range");

    ap_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_COMPRESS && state_next == ST_COMPRESS |=> rnd_cnt_reg == '0)
        else $error("compression did not start at round zero");

    ap_fresh_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && digest.last_word |=> item_ready && byte_cnt_reg == '0)
        else $error("block not cleared after the last digest word");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sha1md_pkg::*;

    localparam int MSG_ITEM_TARGET = 230;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD_CYCLES = 400;

    // Tracks the expected digest words of the stream, predicted from the accepted items.
    class sha1_digest_tracker;
        word_t         chain [5];
        logic [7:0]    blk_bytes [64];
        logic [63:0]   bit_total;
        digest_item_t  expected_words [$];
        int            mismatches;

        function new();
            mismatches = 0;
            foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hEFCDAB89;
            chain[2] = 32'h98BADCFE;
            chain[3] = 32'h10325476;
            chain[4] = 32'hC3D2E1F0;
            bit_total = 64'd0;
        endfunction

        function word_t rotl(word_t v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void compress();
            word_t w [80];
            word_t a, b, c, d, e, f, k, t;
            for (int i = 0; i < 16; i++)
                w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
            for (int i = 16; i < 80; i++)
                w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int i = 0; i < 80; i++)
            begin
                if (i < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end
                else if (i < 40)
                begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end
                else if (i < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                t = rotl(a, 5) + f + e + k + w[i];
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void push_byte(logic [7:0] v);
            logic [5:0] pos;
            pos = bit_total[8:3];
            blk_bytes[pos] = v;
            bit_total += 64'd8;
            if (pos == 6'd63)
                compress();
        endfunction

        function void absorb_item(msg_item_t m);
            logic [63:0]  len_bits;
            digest_item_t w;
            if (m.byte_present)
                push_byte(m.data_byte);
            if (!m.end_of_message)
                return;
            len_bits = bit_total;
            push_byte(8'h80);
            // Zero fill until the fill position reaches byte 56 of the block.
            while (bit_total[8:3] != 6'd56)
                push_byte(8'h00);
            for (int i = 0; i < 8; i++)
                push_byte(len_bits[63 - 8*i -: 8]);
            for (int i = 0; i < 5; i++)
            begin
                w.digest_word = chain[i];
                w.word_index = 3'(i);
                w.last_word = (i == 4);
                expected_words.push_back(w);
            end
            restart();
        endfunction

        function void check_word(digest_item_t got);
            digest_item_t exp;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected digest transaction %h/%0d/%0d", $time,
                         got.digest_word, got.word_index, got.last_word);
                mismatches++;
                return;
            end
            exp = expected_words.pop_front();
            if (got.digest_word !== exp.digest_word)
            begin
                $display("%0t: digest_word expected %h actual %h", $time,
                         exp.digest_word, got.digest_word);
                mismatches++;
            end
            if (got.word_index !== exp.word_index)
            begin
                $display("%0t: word_index expected %0d actual %0d", $time,
                         exp.word_index, got.word_index);
                mismatches++;
            end
            if (got.last_word !== exp.last_word)
            begin
                $display("%0t: last_word expected %0d actual %0d", $time,
                         exp.last_word, got.last_word);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    msg_item_t    item;
    logic         digest_valid;
    logic         digest_ready;
    digest_item_t digest;

    sha1_digest_tracker tracker = new();

    int msg_items;
    int cycle_count;
    int words_taken;
    int rx_hold;
    bit tx_burst;
    bit rx_burst;

    sha1_message_digest dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Called right after a rising edge; returns at the edge that accepts the transaction.
    task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{data_byte: data, byte_present: present, end_of_message: eom};
        do
            @(posedge clk);
        while (!item_ready);
        tracker.absorb_item('{data_byte: data, byte_present: present, end_of_message: eom});
        msg_items++;
    endtask

    task automatic send_message(input int len);
        bit end_with_byte;
        tx_burst = ($urandom_range(0, 3) == 0);
        end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            // Occasional empty transactions inside the message.
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (i == len - 1));
        end
        if (!end_with_byte)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // Receiver: ready drops for a drawn number of cycles after each accepted word.
    initial
    begin
        digest_ready <= 1'b0;
        rx_hold = 0;
        rx_burst = 1'b0;
        words_taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (digest_valid && digest_ready)
            begin
                tracker.check_word(digest);
                words_taken++;
                if ($urandom_range(0, 14) == 0)
                    rx_burst = ~rx_burst;
                if (words_taken % 53 == 7)
                    rx_hold = LONG_HOLD_CYCLES;
                else
                    rx_hold = rx_burst ? 0 : $urandom_range(0, 11);
            end
            else if (!digest_ready && rx_hold > 0)
                rx_hold--;
            digest_ready <= (rx_hold == 0);
        end
    end

    initial
    begin
        int len;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        msg_items = 0;
        tx_burst = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty transaction, then the empty message.
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        wait_drained();
        @(posedge clk);
        tx_burst = 1'b1;
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hFE, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h55, 1'b1, 1'b1);
        send_item(8'hAA, 1'b1, 1'b1);

        // Padding that fits in the last block, then a message ending on a block edge.
        send_message(55);
        send_message(64);
        while (msg_items < MSG_ITEM_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 62;
                    4: len = 63;
                    default: len = 64;
                endcase
            end
            else
                len = $urandom_range(0, 20);
            send_message(len);
            if ($urandom_range(0, 7) == 0)
            begin
                wait_drained();
                @(posedge clk);
            end
        end

        item_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sha1md_pkg.sv
hw/rtl/sha1md_sched.sv
hw/rtl/sha1md_round.sv
hw/rtl/sha1_message_digest.sv
tb/testbench.sv
